// ===== rtl/histogram_entropy_engine_core_macros.svh =====
// ----------------------------------------------------------------------------
// histogram entropy engine assertion macros
// shared property shapes, clocked on i_clk with reset i_rst_n
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_ENTROPY_ENGINE_CORE_MACROS_SVH
`define HISTOGRAM_ENTROPY_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define HEE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HEE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hee_pkg.sv =====
// ----------------------------------------------------------------------------
// hee_pkg
// shared codes and constants of the histogram entropy engine
// ----------------------------------------------------------------------------
`default_nettype none

package hee_pkg;

    parameter int LOG_FRAC_BITS = 30;
    parameter int ENT_W         = 27;
    parameter logic [31:0] LN2_Q32 = 32'd2977044472;
    parameter logic [ENT_W-1:0] ENT_MAX = 27'h7FF_FFFF;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_WIDTH = 2'd1,
        ST_NO_SAMPLES = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_RANGE_MIN = 2'd0,
        CFG_RANGE_MAX = 2'd1,
        CFG_BIN_COUNT = 2'd2
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== rtl/histogram_entropy_engine_core.sv =====
// ----------------------------------------------------------------------------
// histogram_entropy_engine_core
// bins sample magnitudes into a memory histogram, emits shannon entropy on last
// ----------------------------------------------------------------------------
//  channel   handshake                       payload
//  request   start / busy                    i_sample, i_last
//  result    o_valid (one-cycle strobe)      o_entropy, o_status
//  config    i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
//  a request keeps busy high through a restoring division for the bin (skipped
//  when the bin clamps), then a read-modify-write of the bin memory.
//  on last, a log2 of the sample total precedes a walk over all MAX_BINS entries;
//  each filled bin in use takes a division and a log2 (by the log2 unit), and
//  the sum is then rounded and scaled by ln2 to give the result.
//  after reset a clearing pass over all MAX_BINS entries keeps busy high; results
//  and config writes are never stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "histogram_entropy_engine_core_macros.svh"

module histogram_entropy_engine_core #(
    parameter int MAX_BINS    = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [31:0]            i_sample,
    input  wire logic                          i_last,
    output logic                               o_valid,
    output logic [hee_pkg::ENT_W-1:0]          o_entropy,
    output logic [1:0]                         o_status,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);

    localparam int CW   = COUNT_WIDTH;
    localparam int QW   = $clog2(MAX_BINS);
    localparam int NBW  = $clog2(MAX_BINS + 1);
    localparam int CMPW = (NBW > 9) ? NBW : 9;
    localparam int EW   = $clog2(CW);
    localparam int FB   = hee_pkg::LOG_FRAC_BITS;
    localparam int LW   = EW + FB;
    localparam int DW   = LW - 6;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_BIN, S_CMP, S_MUL, S_BDIV, S_RD, S_UPD,
        S_TLOG, S_TWAIT, S_TSH, S_WRD, S_WGET, S_WPREP, S_WDINIT, S_WDIV,
        S_WLOGW, S_WMUL, S_WACC, S_FIN1, S_FIN2, S_FIN3
    } t_state;

    t_state                  r_state;
    logic signed [31:0]      r_min;
    logic signed [31:0]      r_max;
    logic [8:0]              r_bin_count;

    logic signed [31:0]      r_smp;
    logic                    r_last;
    logic signed [33:0]      r_diff;
    logic signed [32:0]      r_den;
    logic [31:0]             r_dn;
    logic [31:0]             r_dab;
    logic [QW-1:0]           r_num;
    logic [32:0]             r_rem;
    logic [QW-1:0]           r_q;
    logic [5:0]              r_cnt;
    logic [QW-1:0]           r_bin;
    logic [QW-1:0]           r_idx;
    logic [CW-1:0]           r_total;
    logic [CW-1:0]           r_c;
    logic [LW-1:0]           r_ln;
    logic [EW-1:0]           r_s;
    logic [31:0]             r_nsh;
    logic [31:0]             r_cs;
    logic [32:0]             r_p;
    logic [DW-1:0]           r_d;
    logic [33+DW-1:0]        r_prod;
    logic [63:0]             r_acc;
    logic [31:0]             r_hb;
    logic [63:0]             r_h;
    logic                    r_valid;
    logic [hee_pkg::ENT_W-1:0] r_ent;
    hee_pkg::t_status        r_status;

    logic [CW-1:0]           mem [MAX_BINS];
    logic [CW-1:0]           r_rdata;
    logic                    w_we;
    logic [QW-1:0]           w_wa;
    logic [CW-1:0]           w_wd;
    logic [QW-1:0]           w_ra;

    logic                    w_log_start;
    logic [CW-1:0]           w_log_x;
    logic                    w_log_done;
    logic [LW-1:0]           w_log_val;

    logic [NBW-1:0]          w_nb;
    logic [CMPW-1:0]         w_bc_ext;
    logic signed [32:0]      w_sx;
    logic signed [32:0]      w_mag;
    logic signed [33:0]      w_diff_n;
    logic signed [32:0]      w_dab;
    logic [32+NBW-1:0]       w_num;
    logic [32:0]             w_brem;
    logic                    w_bge;
    logic [32:0]             w_prem;
    logic                    w_pge;
    logic [EW-1:0]           w_e_tot;
    logic [EW-1:0]           w_s;
    logic                    w_ok;
    logic                    w_use;
    logic [32:0]             w_hr;
    logic                    w_accept;

    // bins in use: zero means one, clamp at MAX_BINS
    assign w_bc_ext = CMPW'(r_bin_count);
    always_comb begin
        if (r_bin_count == 9'd0) begin
            w_nb = NBW'(1);
        end else if (w_bc_ext > CMPW'(MAX_BINS)) begin
            w_nb = NBW'(MAX_BINS);
        end else begin
            w_nb = NBW'(w_bc_ext);
        end
    end

    assign w_sx     = {r_smp[31], r_smp};
    assign w_mag    = w_sx[32] ? -w_sx : w_sx;
    assign w_diff_n = r_den[32] ? -r_diff : r_diff;
    assign w_dab    = r_den[32] ? -r_den : r_den;
    assign w_num    = (32+NBW)'(r_dn) * (32+NBW)'(w_nb);

    assign w_brem = {r_rem[31:0], r_num[QW-1]};
    assign w_bge  = (w_brem >= {1'b0, r_dab});
    assign w_prem = {r_rem[31:0], 1'b0};
    assign w_pge  = (w_prem >= {1'b0, r_nsh});

    assign w_e_tot = r_ln[LW-1:FB];
    assign w_s     = (w_e_tot > EW'(31)) ? EW'(w_e_tot - EW'(31)) : '0;

    assign w_ok  = (r_min != r_max) && (r_total != '0);
    assign w_use = w_ok && (r_rdata != '0) && (CMPW'(r_idx) < CMPW'(w_nb));
    assign w_hr  = 33'((r_h + 64'h8000_0000) >> 32);

    assign w_accept = start && !busy;

    // memory port selection
    always_comb begin
        w_we = 1'b0;
        w_wa = r_idx;
        w_wd = '0;
        w_ra = r_idx;
        case (r_state)
            S_CLR:  w_we = 1'b1;
            S_WGET: w_we = 1'b1;
            S_RD:   w_ra = r_bin;
            S_UPD: begin
                w_we = 1'b1;
                w_wa = r_bin;
                w_wd = (&r_rdata) ? r_rdata : r_rdata + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rdata <= mem[w_ra];
    end

    assign w_log_start = (r_state == S_TLOG) || (r_state == S_WPREP);
    assign w_log_x     = (r_state == S_TLOG) ? r_total : r_c;

    hee_log2 #(
        .CW (CW)
    ) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_log_start),
        .i_x     (w_log_x),
        .o_done  (w_log_done),
        .o_log   (w_log_val)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= 32'sd0;
            r_max       <= 32'sd65536;
            r_bin_count <= 9'd256;
        end else if (i_cfg_valid) begin
            unique case (hee_pkg::t_cfg_idx'(i_cfg_index))
                hee_pkg::CFG_RANGE_MIN: r_min       <= i_cfg_data;
                hee_pkg::CFG_RANGE_MAX: r_max       <= i_cfg_data;
                hee_pkg::CFG_BIN_COUNT: r_bin_count <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == QW'(MAX_BINS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_smp   <= i_sample;
                        r_last  <= i_last;
                        r_state <= S_BIN;
                    end
                end
                S_BIN: begin
                    r_diff  <= {w_mag[32], w_mag} - {{2{r_min[31]}}, r_min};
                    r_den   <= {r_max[31], r_max} - {r_min[31], r_min};
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_den == '0 || w_diff_n[33]) begin
                        r_bin   <= '0;
                        r_state <= S_RD;
                    end else if (w_diff_n >= {1'b0, w_dab}) begin
                        r_bin   <= QW'(w_nb - 1'b1);
                        r_state <= S_RD;
                    end else begin
                        r_dn    <= w_diff_n[31:0];
                        r_dab   <= w_dab[31:0];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_rem   <= 33'(w_num >> QW);
                    r_num   <= QW'(w_num);
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_BDIV;
                end
                S_BDIV: begin
                    r_rem <= w_bge ? w_brem - {1'b0, r_dab} : w_brem;
                    r_num <= QW'({r_num, 1'b0});
                    r_q   <= QW'({r_q, w_bge});
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'(QW - 1)) begin
                        r_bin   <= QW'({r_q, w_bge});
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_UPD;
                S_UPD: begin
                    if (!(&r_total)) begin
                        r_total <= r_total + 1'b1;
                    end
                    r_state <= r_last ? S_TLOG : S_IDLE;
                end
                S_TLOG: r_state <= S_TWAIT;
                S_TWAIT: begin
                    if (w_log_done) begin
                        r_ln    <= w_log_val;
                        r_state <= S_TSH;
                    end
                end
                S_TSH: begin
                    r_s     <= w_s;
                    r_nsh   <= 32'(({32'b0, r_total}) >> w_s);
                    r_acc   <= '0;
                    r_idx   <= '0;
                    r_state <= S_WRD;
                end
                S_WRD: r_state <= S_WGET;
                S_WGET: begin
                    r_c <= r_rdata;
                    if (w_use) begin
                        r_state <= S_WPREP;
                    end else if (r_idx == QW'(MAX_BINS - 1)) begin
                        r_state <= S_FIN1;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_WRD;
                    end
                end
                S_WPREP: begin
                    r_cs    <= 32'(({32'b0, r_c}) >> r_s);
                    r_state <= S_WDINIT;
                end
                S_WDINIT: begin
                    if (r_cs >= r_nsh) begin
                        r_rem <= {1'b0, r_cs - r_nsh};
                        r_p   <= 33'd1;
                    end else begin
                        r_rem <= {1'b0, r_cs};
                        r_p   <= 33'd0;
                    end
                    r_cnt   <= '0;
                    r_state <= S_WDIV;
                end
                S_WDIV: begin
                    r_rem <= w_pge ? w_prem - {1'b0, r_nsh} : w_prem;
                    r_p   <= {r_p[31:0], w_pge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd31) begin
                        r_state <= S_WLOGW;
                    end
                end
                S_WLOGW: begin
                    if (w_log_done) begin
                        r_d     <= (r_ln > w_log_val) ? DW'((r_ln - w_log_val) >> 6) : '0;
                        r_state <= S_WMUL;
                    end
                end
                S_WMUL: begin
                    r_prod  <= (33+DW)'(r_p) * (33+DW)'(r_d);
                    r_state <= S_WACC;
                end
                S_WACC: begin
                    r_acc <= r_acc + 64'(r_prod);
                    if (r_idx == QW'(MAX_BINS - 1)) begin
                        r_state <= S_FIN1;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_WRD;
                    end
                end
                S_FIN1: begin
                    r_hb    <= 32'((r_acc + 64'h8000_0000) >> 32);
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    r_h     <= 64'(r_hb) * 64'(hee_pkg::LN2_Q32);
                    r_state <= S_FIN3;
                end
                S_FIN3: begin
                    if (r_min == r_max) begin
                        r_status <= hee_pkg::ST_ZERO_WIDTH;
                        r_ent    <= '0;
                    end else if (r_total == '0) begin
                        r_status <= hee_pkg::ST_NO_SAMPLES;
                        r_ent    <= '0;
                    end else begin
                        r_status <= hee_pkg::ST_OK;
                        r_ent    <= (w_hr > 33'(hee_pkg::ENT_MAX)) ? hee_pkg::ENT_MAX
                                                                   : hee_pkg::ENT_W'(w_hr);
                    end
                    r_valid <= 1'b1;
                    r_total <= '0;
                    r_idx   <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_entropy   = r_ent;
    assign o_status    = r_status;

    `HEE_ASSERT_NEXT(a_accept_busy, w_accept, busy, "request accepted but block not busy")
    `HEE_ASSERT_NEXT(a_result_pulse, o_valid, !o_valid, "result strobe longer than one cycle")
    `HEE_ASSERT_NOW(a_status_zero, o_valid && (o_status != hee_pkg::ST_OK), o_entropy == '0, "nonzero entropy with error status")
    `HEE_ASSERT_NOW(a_result_idle, o_valid, !busy && r_total == '0, "result while histogram not cleared")

endmodule

`default_nettype wire

// ===== rtl/hee_log2.sv =====
// ----------------------------------------------------------------------------
// hee_log2
// iterative log2 unit: normalizes one bit a cycle, then one squaring a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hee_log2 #(
    parameter int CW = 32
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_start,
    input  wire logic [CW-1:0]                             i_x,
    output logic                                           o_done,
    output logic [$clog2(CW)+hee_pkg::LOG_FRAC_BITS-1:0]   o_log
);

    localparam int EW = $clog2(CW);
    localparam int FB = hee_pkg::LOG_FRAC_BITS;

    typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} t_lstate;

    t_lstate           r_state;
    logic              r_done;
    logic [CW+31:0]    r_n;
    logic [EW-1:0]     r_e;
    logic [31:0]       r_m;
    logic [FB-1:0]     r_f;
    logic [4:0]        r_k;

    logic [63:0]       w_prod;
    logic [32:0]       w_t;

    assign w_prod = 64'(r_m) * 64'(r_m);
    assign w_t    = w_prod[63:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_f <= '0;
                        if (i_x == '0) begin
                            r_e    <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_done  <= 1'b0;
                            r_n     <= {i_x, 32'b0};
                            r_e     <= EW'(CW - 1);
                            r_state <= L_NORM;
                        end
                    end
                end
                L_NORM: begin
                    if (r_n[CW+31]) begin
                        r_m     <= r_n[CW+31 -: 32];
                        r_k     <= '0;
                        r_state <= L_SQ;
                    end else begin
                        r_n <= {r_n[CW+30:0], 1'b0};
                        r_e <= r_e - 1'b1;
                    end
                end
                L_SQ: begin
                    r_m <= w_t[32] ? w_t[32:1] : w_t[31:0];
                    r_f <= {r_f[FB-2:0], w_t[32]};
                    r_k <= r_k + 1'b1;
                    if (r_k == 5'(FB - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= L_IDLE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_log  = {r_e, r_f};

endmodule

`default_nettype wire
